// File: sv/hhr_pkg.sv
// Shared types and constants for the hash history repetition check.
// Holds the opcode type and the controller/datapath command and status structs.
// Depends on nothing.
`default_nettype none

package hhr_pkg;

	// Default number of stored hashes.
	localparam int HISTORY_DEPTH_DEF = 1024;

	// Field widths.
	localparam int HASH_W = 64;
	localparam int CLK_W  = 8;
	localparam int OPC_W  = 2;

	// Lookback distance counter: holds up to the largest clock plus the stride.
	localparam int DIST_W = CLK_W + 1;

	// First lookback distance and the step between compared entries.
	localparam logic [DIST_W-1:0] MIN_LOOKBACK    = DIST_W'(4);
	localparam logic [DIST_W-1:0] LOOKBACK_STRIDE = DIST_W'(2);

	// Operation codes.
	typedef enum logic [OPC_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CHECK = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;        // write the hash at the pointer, advance the pointer
		logic pop;         // step the pointer back, zero the vacated entry
		logic chk_start;   // capture the clock, read the newest entry
		logic ld_newest;   // capture the newest hash, read the first probe
		logic probe_next;  // read the next probe at two entries further back
		logic clr_start;   // reset the pointer and the sweep address
		logic sweep;       // zero one entry and advance the sweep address
	} hhr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic short_clock; // request clock is below the minimum lookback
		logic hash_eq;     // arriving probe equals the newest hash
		logic last_probe;  // arriving probe is the farthest one allowed
		logic sweep_last;  // sweep is at the last entry
	} hhr_sts_t;

endpackage

`default_nettype wire

// File: sv/hhr_datapath.sv
// Datapath of the hash history repetition check: hash memory, write pointer,
// probe address generation and the compare against the newest hash.
// Depends on hhr_pkg.
`default_nettype none

module hhr_datapath #(
	parameter int DEPTH = hhr_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [hhr_pkg::HASH_W-1:0]  board_key,
	input  wire logic [hhr_pkg::CLK_W-1:0]   halfmove_clock,
	input  wire hhr_pkg::hhr_cmd_t           cmd,
	output hhr_pkg::hhr_sts_t                sts
);
	import hhr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);

	// Index that lies span entries behind idx, wrapping modulo the depth.
	function automatic logic [AW-1:0] wrap_back(input logic [AW-1:0] idx,
	                                            input logic [DIST_W-1:0] span);
		logic [AW:0] idx_x;
		logic [AW:0] dist_x;
		idx_x  = {1'b0, idx};
		dist_x = (AW + 1)'(span);
		if (idx_x >= dist_x)
			return AW'(idx_x - dist_x);
		else
			return AW'(idx_x + DEPTH_X - dist_x);
	endfunction

	logic [HASH_W-1:0] mem [DEPTH];

	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     sweep_q;
	logic [AW-1:0]     newest_idx_q;
	logic [DIST_W-1:0] dist_q;
	logic [CLK_W-1:0]  clock_q;
	logic [HASH_W-1:0] newest_q;
	logic [HASH_W-1:0] rd_q;

	logic [AW-1:0]     wp_inc;
	logic [AW-1:0]     wp_dec;
	logic [AW-1:0]     newest_idx;
	logic [DIST_W-1:0] dist_next;
	logic [AW-1:0]     probe_addr;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [HASH_W-1:0] wr_data;
	logic              wr_en;

	// Pointer neighbors.
	assign wp_inc     = (wp_q == LAST_IDX) ? '0 : AW'(wp_q + 1'b1);
	assign wp_dec     = wrap_back(wp_q, DIST_W'(1));
	assign newest_idx = wp_dec;

	// Next probe distance: the first one after the newest read, else two further.
	assign dist_next  = cmd.ld_newest ? MIN_LOOKBACK : DIST_W'(dist_q + LOOKBACK_STRIDE);
	assign probe_addr = wrap_back(newest_idx_q, dist_next);
	assign rd_addr    = cmd.chk_start ? newest_idx : probe_addr;

	// Write port selection.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wp_q;
		wr_data = '0;
		if (cmd.push) begin
			wr_en   = 1'b1;
			wr_data = board_key;
		end else if (cmd.pop) begin
			wr_en   = 1'b1;
			wr_addr = wp_dec;
		end else if (cmd.sweep) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
		end
	end

	// Hash memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// Pointer and sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			sweep_q <= '0;
		end else begin
			if (cmd.push)
				wp_q <= wp_inc;
			else if (cmd.pop)
				wp_q <= wp_dec;
			else if (cmd.clr_start)
				wp_q <= '0;

			if (cmd.clr_start)
				sweep_q <= '0;
			else if (cmd.sweep)
				sweep_q <= (sweep_q == LAST_IDX) ? '0 : AW'(sweep_q + 1'b1);
		end
	end

	// Check context: clock limit, newest index and hash, probe distance.
	always_ff @(posedge clk) begin
		if (cmd.chk_start) begin
			clock_q      <= halfmove_clock;
			newest_idx_q <= newest_idx;
		end
		if (cmd.ld_newest)
			newest_q <= rd_q;
		if (cmd.ld_newest || cmd.probe_next)
			dist_q <= dist_next;
	end

	// Status back to the controller.
	assign sts.short_clock = (DIST_W'(halfmove_clock) < MIN_LOOKBACK);
	assign sts.hash_eq     = (rd_q == newest_q);
	assign sts.last_probe  = (DIST_W'(dist_q + LOOKBACK_STRIDE) > DIST_W'(clock_q));
	assign sts.sweep_last  = (sweep_q == LAST_IDX);

endmodule

`default_nettype wire

// File: sv/hhr_controller.sv
// Controller of the hash history repetition check: sequences requests,
// the clearing sweep and the probe loop, and registers the result strobe.
// Depends on hhr_pkg.
`default_nettype none

module hhr_controller (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [hhr_pkg::OPC_W-1:0]  opcode,
	input  wire hhr_pkg::hhr_sts_t          sts,
	output hhr_pkg::hhr_cmd_t               cmd,
	output logic                            busy,
	output logic                            done,
	output logic                            repetition_found
);
	import hhr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_NEWEST,
		S_PROBE
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   found_q;
	op_t    op;

	assign op               = op_t'(opcode);
	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign repetition_found = found_q;

	// Datapath commands for the current state and request.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op)
						OP_PUSH:  cmd.push      = 1'b1;
						OP_POP:   cmd.pop       = 1'b1;
						OP_CHECK: cmd.chk_start = !sts.short_clock;
						OP_CLEAR: cmd.clr_start = 1'b1;
						default:  cmd           = '0;
					endcase
				end
			end
			S_SWEEP:  cmd.sweep     = 1'b1;
			S_NEWEST: cmd.ld_newest = 1'b1;
			S_PROBE:  cmd.probe_next = !sts.hash_eq && !sts.last_probe;
			default:  cmd = '0;
		endcase
	end

	// State and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			found_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (op)
							OP_CHECK: begin
								if (sts.short_clock)
									done_q <= 1'b1;
								else
									state_q <= S_NEWEST;
							end
							OP_CLEAR: begin
								done_q  <= 1'b1;
								state_q <= S_SWEEP;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_SWEEP: begin
					if (sts.sweep_last)
						state_q <= S_IDLE;
				end
				S_NEWEST: state_q <= S_PROBE;
				S_PROBE: begin
					if (sts.hash_eq) begin
						done_q  <= 1'b1;
						found_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (sts.last_probe) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/hash_history_repetition_check.sv
// Top level of the hash history repetition check.
// Joins hhr_controller and hhr_datapath; depends on hhr_pkg.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   carries opcode (push, pop, check, clear), board_key and
//   halfmove_clock. Every request gives one result: done is high for one
//   cycle with repetition_found, and the receiver cannot hold it off.
//   Push, pop and a check whose clock is below 4 give their result in the
//   cycle after the request, and another request may follow at once, so
//   these run at one per cycle.
//   A check with clock c of at least 4 reads the newest entry and then one
//   entry per cycle at distances 4, 6, ... up to c over the single read port
//   of the hash memory. The result comes once the first match or the last
//   allowed distance has been read; busy is high until then.
//   Clear gives its result in the next cycle and then zeroes the memory one
//   entry per cycle, every entry in turn, with busy high.
//   After reset the same clearing sweep runs over every entry before
//   the first request is taken.
`default_nettype none

module hash_history_repetition_check #(
	parameter int HISTORY_DEPTH = hhr_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [hhr_pkg::OPC_W-1:0]  opcode,
	input  wire logic [hhr_pkg::HASH_W-1:0] board_key,
	input  wire logic [hhr_pkg::CLK_W-1:0]  halfmove_clock,
	output logic                            done,
	output logic                            repetition_found
);
	import hhr_pkg::*;

	hhr_cmd_t cmd;
	hhr_sts_t sts;

	// Sequencing of requests, sweep and probe loop.
	hhr_controller u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.opcode           (opcode),
		.sts              (sts),
		.cmd              (cmd),
		.busy             (busy),
		.done             (done),
		.repetition_found (repetition_found)
	);

	// Hash memory, pointer and compare.
	hhr_datapath #(
		.DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.board_key      (board_key),
		.halfmove_clock (halfmove_clock),
		.cmd            (cmd),
		.sts            (sts)
	);

	// A check with a short clock answers false in the next cycle.
	a_short_check: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_CHECK) && (halfmove_clock < 8'd4)
		|=> done && !repetition_found)
		else $error("short check did not answer false in the next cycle");

	// A push or pop answers false in the next cycle.
	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((opcode == OP_PUSH) || (opcode == OP_POP))
		|=> done && !repetition_found)
		else $error("push or pop did not answer in the next cycle");

	// A clear starts the sweep, which holds off requests.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_CLEAR) |=> busy && done)
		else $error("clear did not start the sweep");

	// A found repetition only appears with the result strobe.
	a_found_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		repetition_found |-> done && !busy)
		else $error("repetition_found without a result");

endmodule

`default_nettype wire
